### design/fas_pkg.sv
// Shared constants and types for the truncating single-precision adder.
package fas_pkg;
  localparam int unsigned DataWidth = 32;
  localparam logic [7:0] ExpMax = 8'hFF;
  localparam logic [31:0] DefaultNan = 32'h7FC00000;
  localparam int unsigned PipeDepth = 4;

  typedef struct packed {
    logic [31:0] bits;
    logic        done;
  } special_t;

  // Leading-zero count of a 24-bit significand (24 when zero).
  function automatic logic [4:0] lzc24(input logic [23:0] m);
    logic [4:0] n;
    n = 5'd24;
    for (int i = 0; i < 24; i++) begin
      if (m[i]) begin
        n = 5'(23 - i);
      end
    end
    return n;
  endfunction
endpackage

### design/float32_add_sub_truncating.sv
// Top level: four-stage pipelined truncating single-precision add/subtract.
// Throughput: one operation per cycle; busy is never raised.
// Stages: unpack/compare, align and add, leading-zero count, normalize and pack.
// Reset (rst, synchronous) clears the stage valid bits; no results follow reset.
// Results are shown for one cycle with done high; the receiver cannot stall.
module float32_add_sub_truncating
  import fas_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [DataWidth-1:0] operand_a,
  input  logic [DataWidth-1:0] operand_b,
  input  logic                 operation,
  output logic                 done,
  output logic [DataWidth-1:0] sum_bits
);
  logic [PipeDepth-1:0] valid;
  logic accept;

  // stage 1
  logic [31:0] b_eff;
  special_t    special0;
  special_t    s1_special;
  logic        s1_sa, s1_sb;
  logic [23:0] s1_big, s1_small;
  logic [7:0]  s1_exp, s1_diff;

  // stage 2
  logic [24:0] sum_full;
  logic [23:0] small_shift;
  special_t    s2_special;
  logic        s2_sign, s2_sub;
  logic [24:0] s2_mant;
  logic [7:0]  s2_exp;

  // stage 3
  special_t    s3_special;
  logic        s3_sign, s3_sub;
  logic [24:0] s3_mant;
  logic [7:0]  s3_exp;
  logic [4:0]  s3_lz;

  logic [31:0] result_next;
  logic [9:0]  re;
  logic [23:0] norm;
  logic [4:0]  shamt;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign done   = valid[PipeDepth-1];

  fas_special u_special (.a(operand_a[31:0]), .b(b_eff), .special(special0));

  always_comb begin
    b_eff = operand_b[31:0] ^ {operation, 31'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[PipeDepth-2:0], accept};
    end
  end

  // stage 1: order operands by exponent, then by mantissa when exponents match
  always_ff @(posedge clk) begin
    logic [23:0] ma, mb;
    logic        a_big;
    ma = {operand_a[30:23] != 8'd0, operand_a[22:0]};
    mb = {b_eff[30:23] != 8'd0, b_eff[22:0]};
    a_big = (operand_a[30:23] > b_eff[30:23]) ||
            ((operand_a[30:23] == b_eff[30:23]) && (ma >= mb));
    s1_special <= special0;
    s1_sa      <= a_big ? operand_a[31] : b_eff[31];
    s1_sb      <= a_big ? b_eff[31] : operand_a[31];
    s1_big     <= a_big ? ma : mb;
    s1_small   <= a_big ? mb : ma;
    s1_exp     <= a_big ? operand_a[30:23] : b_eff[30:23];
    s1_diff    <= a_big ? operand_a[30:23] - b_eff[30:23] : b_eff[30:23] - operand_a[30:23];
  end

  // stage 2: truncating align and add/subtract
  always_comb begin
    small_shift = (s1_diff >= 8'd32) ? 24'd0 : (s1_small >> s1_diff);
    if (s1_sa == s1_sb) begin
      sum_full = {1'b0, s1_big} + {1'b0, small_shift};
    end else begin
      sum_full = {1'b0, s1_big} - {1'b0, small_shift};
    end
  end

  always_ff @(posedge clk) begin
    s2_special <= s1_special;
    s2_sign    <= s1_sa;
    s2_sub     <= s1_sa != s1_sb;
    s2_mant    <= sum_full;
    s2_exp     <= s1_exp;
  end

  // stage 3: leading-zero count
  always_ff @(posedge clk) begin
    s3_special <= s2_special;
    s3_sign    <= s2_sign;
    s3_sub     <= s2_sub;
    s3_mant    <= s2_mant;
    s3_exp     <= s2_exp;
    s3_lz      <= lzc24(s2_mant[23:0]);
  end

  // stage 4: normalize, range check, pack
  always_comb begin
    result_next = '0;
    norm  = '0;
    shamt = '0;
    re    = {2'b0, s3_exp};
    if (s3_special.done) begin
      result_next = s3_special.bits;
    end else if (!s3_sub) begin
      if (s3_mant[24]) begin
        norm = s3_mant[24:1];
        re   = re + 10'd1;
      end else begin
        norm = s3_mant[23:0];
      end
      if (re >= 10'd255) result_next = {s3_sign, ExpMax, 23'b0};
      else if (re == 10'd0) result_next = {s3_sign, 31'b0};
      else result_next = {s3_sign, re[7:0], norm[22:0]};
    end else if (s3_mant[23:0] == '0) begin
      result_next = '0;
    end else begin
      // shift stops early when the exponent reaches zero
      shamt = ({5'b0, s3_lz} <= {2'b0, s3_exp}) ? s3_lz : s3_exp[4:0];
      norm  = s3_mant[23:0] << shamt;
      re    = {2'b0, s3_exp} - {5'b0, shamt};
      if (re == 10'd0) result_next = {s3_sign, 31'b0};
      else result_next = {s3_sign, re[7:0], norm[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    sum_bits <= result_next;
  end

  assert property (@(posedge clk) disable iff (rst) accept |-> ##4 done)
    else $error("result strobe missing four cycles after start");
  assert property (@(posedge clk) disable iff (rst) done |-> $past(valid[PipeDepth-2]))
    else $error("done without a matching pipeline entry");
  assert property (@(posedge clk) busy == 1'b0)
    else $error("busy raised");
endmodule

### design/fas_special.sv
// Special-operand classification: NaN, infinity and zero operands.
module fas_special
  import fas_pkg::*;
(
  input  logic [31:0] a,
  input  logic [31:0] b,
  output special_t    special
);
  logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

  always_comb begin
    a_nan  = (a[30:23] == ExpMax) && (a[22:0] != '0);
    b_nan  = (b[30:23] == ExpMax) && (b[22:0] != '0);
    a_inf  = (a[30:23] == ExpMax) && (a[22:0] == '0);
    b_inf  = (b[30:23] == ExpMax) && (b[22:0] == '0);
    a_zero = a[30:0] == '0;
    b_zero = b[30:0] == '0;
    special.done = 1'b1;
    special.bits = a;
    if (a_nan) begin
      special.bits = a;
    end else if (b_nan) begin
      special.bits = b;
    end else if (a_inf) begin
      special.bits = (b_inf && (a[31] != b[31])) ? DefaultNan : a;
    end else if (b_inf) begin
      special.bits = b;
    end else if (a_zero) begin
      special.bits = b;
    end else if (b_zero) begin
      special.bits = a;
    end else begin
      special.done = 1'b0;
    end
  end
endmodule
